>>> design/pts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types, sizes and codes of the priority task selector.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int MAX_TASKS  = 16;
    localparam int NAME_BYTES = 8;

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    // keep only the top NAME_BYTES bytes of a key
    localparam logic [63:0] NAME_MASK = ~64'd0 << (8 * (8 - NAME_BYTES));

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_PICK = 1'b1;

    localparam logic [1:0] ST_ADDED  = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_PICKED = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic [63:0] name;
        logic [7:0]  prio;
        logic [15:0] burst;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

endpackage

>>> design/priority_task_selector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_task_selector_unit
// Non-preemptive priority scheduler: stores tasks and hands out the next one.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one transaction is an add (store a task) or a pick
//   (remove the highest-priority task, ties to the smallest name key, then the
//   lowest slot). Result channel m_*: exactly one transaction per input
//   transaction, in order, with status added, full, picked or empty.
// Operation:
//   An add writes the task RAM in the cycle it is accepted; its result is
//   presented on the next cycle. A pick walks the task RAM one slot per cycle
//   through its single read port and presents its result once the scan is
//   done and the result register is free or being taken.
//   One item is in progress at a time, so no new transaction is taken during
//   a pick, nor while an untaken result still holds the result register.
// Reset:
//   aresetn (synchronous, active low) clears all slot valid bits, the running
//   time and the result valid flag at once; no RAM sweep is needed.
// Stall:
//   The result register holds while m_ready is low; s_ready only rises when
//   the result register is free or being taken in the same cycle.
// ----------------------------------------------------------------------------
module priority_task_selector_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [63:0] s_name_key,
    input  logic [7:0]  s_task_priority,
    input  logic [15:0] s_burst_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [63:0] m_picked_name,
    output logic [7:0]  m_picked_priority,
    output logic [15:0] m_picked_burst,
    output logic [31:0] m_elapsed_time
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // control state
    logic [1:0]                    state_reg, state_next;
    logic [pts_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                          pend_reg, pend_next;
    logic [pts_pkg::IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic                          found_reg, found_next;
    logic [pts_pkg::MAX_TASKS-1:0] valid_reg, valid_next;
    logic [31:0]                   time_reg, time_next;
    logic                          m_valid_reg, m_valid_next;

    // payload state
    pts_pkg::slot_t                best_reg, best_next;
    logic [pts_pkg::IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [1:0]                    status_reg, status_next;
    pts_pkg::slot_t                out_reg, out_next;
    logic [31:0]                   elapsed_reg, elapsed_next;

    // RAM ports
    logic                          wr_en;
    pts_pkg::slot_t                wr_slot;
    logic [pts_pkg::SLOT_W-1:0]    rd_data;
    pts_pkg::slot_t                cand;

    logic                          free_found;
    logic [pts_pkg::IDX_W-1:0]     free_idx;
    logic                          take;
    logic [31:0]                   time_sum;
    logic                          out_free;

    // Task store: one entry per slot. Read data is used only during a scan and
    // writes happen only on an accepted add, so the two never overlap.
    pts_ram #(
        .WIDTH (pts_pkg::SLOT_W),
        .DEPTH (pts_pkg::MAX_TASKS)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (free_idx),
        .wr_data (wr_slot),
        .rd_addr (cnt_reg[pts_pkg::IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign wr_slot.name  = s_name_key & pts_pkg::NAME_MASK;
    assign wr_slot.prio  = s_task_priority;
    assign wr_slot.burst = s_burst_length;

    assign cand = pts_pkg::slot_t'(rd_data);

    // Lowest-numbered free slot: walk downwards so the lowest hit wins.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = pts_pkg::MAX_TASKS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = pts_pkg::IDX_W'(i);
            end
        end
    end

    // Candidate replaces the best so far only when it strictly ranks above,
    // which keeps the lowest slot on a full tie.
    assign take = pend_reg && (!found_reg ||
                  (cand.prio > best_reg.prio) ||
                  ((cand.prio == best_reg.prio) && (cand.name < best_reg.name)));

    assign time_sum = time_reg + 32'(best_reg.burst);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        found_next    = found_reg;
        valid_next    = valid_reg;
        time_next     = time_reg;
        m_valid_next  = m_valid_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        status_next   = status_reg;
        out_next      = out_reg;
        elapsed_next  = elapsed_reg;
        wr_en         = 1'b0;

        // drop the result once it has been taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_operation == pts_pkg::OP_ADD) begin
                        m_valid_next = 1'b1;
                        out_next     = '0;
                        elapsed_next = time_reg;
                        if (free_found) begin
                            wr_en                = 1'b1;
                            valid_next[free_idx] = 1'b1;
                            status_next          = pts_pkg::ST_ADDED;
                        end else begin
                            status_next = pts_pkg::ST_FULL;
                        end
                    end else begin
                        state_next = S_SCAN;
                        cnt_next   = '0;
                        pend_next  = 1'b0;
                        found_next = 1'b0;
                    end
                end
            end
            S_SCAN: begin
                if (take) begin
                    best_next     = cand;
                    best_idx_next = pend_idx_reg;
                    found_next    = 1'b1;
                end
                if (cnt_reg == pts_pkg::CNT_W'(pts_pkg::MAX_TASKS)) begin
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                end else begin
                    // the read issued now returns next cycle; tag it
                    pend_next     = valid_reg[cnt_reg[pts_pkg::IDX_W-1:0]];
                    pend_idx_next = cnt_reg[pts_pkg::IDX_W-1:0];
                    cnt_next      = cnt_reg + 1'b1;
                end
            end
            S_DONE: begin
                // hold until the result register can take the transaction
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                    if (found_reg) begin
                        status_next              = pts_pkg::ST_PICKED;
                        out_next                 = best_reg;
                        elapsed_next             = time_sum;
                        time_next                = time_sum;
                        valid_next[best_idx_reg] = 1'b0;
                    end else begin
                        status_next  = pts_pkg::ST_EMPTY;
                        out_next     = '0;
                        elapsed_next = time_reg;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            valid_reg   <= '0;
            time_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            found_reg   <= found_next;
            valid_reg   <= valid_next;
            time_reg    <= time_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_idx_reg <= pend_idx_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        status_reg   <= status_next;
        out_reg      <= out_next;
        elapsed_reg  <= elapsed_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = status_reg;
    assign m_picked_name     = out_reg.name;
    assign m_picked_priority = out_reg.prio;
    assign m_picked_burst    = out_reg.burst;
    assign m_elapsed_time    = elapsed_reg;

endmodule

>>> design/pts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> design/pts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks of the priority task selector, bound to the top level.
// ----------------------------------------------------------------------------
module pts_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_operation,
    input logic [63:0] s_name_key,
    input logic [7:0]  s_task_priority,
    input logic [15:0] s_burst_length,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [63:0] m_picked_name,
    input logic [7:0]  m_picked_priority,
    input logic [15:0] m_picked_burst,
    input logic [31:0] m_elapsed_time
);

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
        $stable(m_picked_name) && $stable(m_elapsed_time))
        else $error("stalled result changed");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a pick occupies the block for its scan
    a_pick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_operation == pts_pkg::OP_PICK) |=> !s_ready)
        else $error("input accepted during a scan");

    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != pts_pkg::ST_PICKED) |->
        (m_picked_name == 64'd0) && (m_picked_priority == 8'd0) &&
        (m_picked_burst == 16'd0))
        else $error("task fields set on a non-pick result");

endmodule

bind priority_task_selector_unit pts_checker u_pts_checker (.*);
